>>> hdl/rgbcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcs_pkg
// Shared types and constants for the RGB min-max contrast stretch block.
// ----------------------------------------------------------------------------
package rgbcs_pkg;

   localparam int unsigned PIX_W     = 8;
   localparam int unsigned DIV_STEPS = PIX_W;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   localparam logic [PIX_W-1:0] PIX_MAX  = 8'hff;
   localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

   // Input command codes.
   localparam logic CMD_MEASURE = 1'b0;
   localparam logic CMD_STRETCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_WRITE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic measure;  // fold the incoming pixel into the statistics
      logic load;     // capture the incoming pixel and set up the dividers
      logic step;     // one quotient bit in every lane
      logic write;    // move the finished pixel into the output register
   } ctrl_cmd_type;

endpackage

>>> hdl/rgbcs_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcs_lane
// One colour channel: floor(255*(v-min)/(max-min)) by restoring division,
// one quotient bit per step.
// ----------------------------------------------------------------------------
module rgbcs_lane (
   input  logic                         clock,
   input  logic                         load,
   input  logic                         step,
   input  logic [rgbcs_pkg::PIX_W-1:0]  value,
   input  logic [rgbcs_pkg::PIX_W-1:0]  lo,
   input  logic [rgbcs_pkg::PIX_W-1:0]  hi,
   output logic [rgbcs_pkg::PIX_W-1:0]  result
);

   localparam int unsigned W = rgbcs_pkg::PIX_W;

   logic [W-1:0]   rem_ff,  rem_in;
   logic [W-1:0]   nlo_ff,  nlo_in;
   logic [W-1:0]   span_ff, span_in;
   logic [W-1:0]   quot_ff, quot_in;
   logic           zero_ff, zero_in;
   logic           sat_ff,  sat_in;

   logic [W-1:0]   diff;
   logic [2*W-1:0] numer;
   logic [W:0]     trial;
   logic [W:0]     trial_sub;
   logic           fits;

   // 255*d is (d << 8) - d; d < span keeps the top byte below span.
   assign diff      = value - lo;
   assign numer     = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};
   assign trial     = {rem_ff, nlo_ff[W-1]};
   assign trial_sub = trial - {1'b0, span_ff};
   assign fits      = (trial >= {1'b0, span_ff});

   always_comb begin
      rem_in  = rem_ff;
      nlo_in  = nlo_ff;
      span_in = span_ff;
      quot_in = quot_ff;
      zero_in = zero_ff;
      sat_in  = sat_ff;
      if (load) begin
         zero_in = (hi <= lo) || (value <= lo);
         sat_in  = !((hi <= lo) || (value <= lo)) && (value >= hi);
         span_in = hi - lo;
         rem_in  = numer[2*W-1:W];
         nlo_in  = numer[W-1:0];
         quot_in = rgbcs_pkg::PIX_ZERO;
      end else if (step) begin
         rem_in  = fits ? trial_sub[W-1:0] : trial[W-1:0];
         nlo_in  = {nlo_ff[W-2:0], 1'b0};
         quot_in = {quot_ff[W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      nlo_ff  <= nlo_in;
      span_ff <= span_in;
      quot_ff <= quot_in;
      zero_ff <= zero_in;
      sat_ff  <= sat_in;
   end

   always_comb begin
      priority if (zero_ff) begin
         result = rgbcs_pkg::PIX_ZERO;
      end else if (sat_ff) begin
         result = rgbcs_pkg::PIX_MAX;
      end else begin
         result = quot_ff;
      end
   end

endmodule

>>> hdl/rgbcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcs_datapath
// Statistics registers, enable register, three divider lanes and the
// output register.
// ----------------------------------------------------------------------------
module rgbcs_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  rgbcs_pkg::ctrl_cmd_type      cmd,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         frame_start,
   input  logic [rgbcs_pkg::PIX_W-1:0]  blue_in,
   input  logic [rgbcs_pkg::PIX_W-1:0]  green_in,
   input  logic [rgbcs_pkg::PIX_W-1:0]  red_in,
   input  logic [rgbcs_pkg::PIX_W-1:0]  alpha_in,
   output logic [rgbcs_pkg::PIX_W-1:0]  blue_out,
   output logic [rgbcs_pkg::PIX_W-1:0]  green_out,
   output logic [rgbcs_pkg::PIX_W-1:0]  red_out,
   output logic [rgbcs_pkg::PIX_W-1:0]  alpha_out,
   output logic                         was_stretched
);

   localparam int unsigned W = rgbcs_pkg::PIX_W;

   logic         enabled_ff, enabled_in;
   logic [W-1:0] bmin_ff, bmin_in, bmax_ff, bmax_in;
   logic [W-1:0] gmin_ff, gmin_in, gmax_ff, gmax_in;
   logic [W-1:0] rmin_ff, rmin_in, rmax_ff, rmax_in;
   logic [W-1:0] bmin_base, bmax_base, gmin_base, gmax_base, rmin_base, rmax_base;

   logic [W-1:0] raw_b_ff, raw_g_ff, raw_r_ff, raw_a_ff;
   logic         use_ff;
   logic [W-1:0] lane_b, lane_g, lane_r;

   logic [W-1:0] blue_ff, green_ff, red_ff, alpha_ff;
   logic         stretched_ff;

   // A frame start restarts the statistics before the marked pixel counts.
   always_comb begin
      bmin_base = frame_start ? rgbcs_pkg::PIX_MAX  : bmin_ff;
      bmax_base = frame_start ? rgbcs_pkg::PIX_ZERO : bmax_ff;
      gmin_base = frame_start ? rgbcs_pkg::PIX_MAX  : gmin_ff;
      gmax_base = frame_start ? rgbcs_pkg::PIX_ZERO : gmax_ff;
      rmin_base = frame_start ? rgbcs_pkg::PIX_MAX  : rmin_ff;
      rmax_base = frame_start ? rgbcs_pkg::PIX_ZERO : rmax_ff;

      bmin_in = bmin_ff; bmax_in = bmax_ff;
      gmin_in = gmin_ff; gmax_in = gmax_ff;
      rmin_in = rmin_ff; rmax_in = rmax_ff;
      if (cmd.measure) begin
         bmin_in = (blue_in  < bmin_base) ? blue_in  : bmin_base;
         bmax_in = (blue_in  > bmax_base) ? blue_in  : bmax_base;
         gmin_in = (green_in < gmin_base) ? green_in : gmin_base;
         gmax_in = (green_in > gmax_base) ? green_in : gmax_base;
         rmin_in = (red_in   < rmin_base) ? red_in   : rmin_base;
         rmax_in = (red_in   > rmax_base) ? red_in   : rmax_base;
      end
      enabled_in = csr_wr_en ? csr_wr_data : enabled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         bmin_ff    <= rgbcs_pkg::PIX_MAX;
         gmin_ff    <= rgbcs_pkg::PIX_MAX;
         rmin_ff    <= rgbcs_pkg::PIX_MAX;
         bmax_ff    <= rgbcs_pkg::PIX_ZERO;
         gmax_ff    <= rgbcs_pkg::PIX_ZERO;
         rmax_ff    <= rgbcs_pkg::PIX_ZERO;
      end else begin
         enabled_ff <= enabled_in;
         bmin_ff    <= bmin_in;
         gmin_ff    <= gmin_in;
         rmin_ff    <= rmin_in;
         bmax_ff    <= bmax_in;
         gmax_ff    <= gmax_in;
         rmax_ff    <= rmax_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_b_ff <= blue_in;
         raw_g_ff <= green_in;
         raw_r_ff <= red_in;
         raw_a_ff <= alpha_in;
         use_ff   <= enabled_ff;
      end
      if (cmd.write) begin
         blue_ff      <= use_ff ? lane_b : raw_b_ff;
         green_ff     <= use_ff ? lane_g : raw_g_ff;
         red_ff       <= use_ff ? lane_r : raw_r_ff;
         alpha_ff     <= raw_a_ff;
         stretched_ff <= use_ff;
      end
   end

   rgbcs_lane u_lane_b (
      .clock  (clock),
      .load   (cmd.load),
      .step   (cmd.step),
      .value  (blue_in),
      .lo     (bmin_ff),
      .hi     (bmax_ff),
      .result (lane_b)
   );

   rgbcs_lane u_lane_g (
      .clock  (clock),
      .load   (cmd.load),
      .step   (cmd.step),
      .value  (green_in),
      .lo     (gmin_ff),
      .hi     (gmax_ff),
      .result (lane_g)
   );

   rgbcs_lane u_lane_r (
      .clock  (clock),
      .load   (cmd.load),
      .step   (cmd.step),
      .value  (red_in),
      .lo     (rmin_ff),
      .hi     (rmax_ff),
      .result (lane_r)
   );

   assign blue_out      = blue_ff;
   assign green_out     = green_ff;
   assign red_out       = red_ff;
   assign alpha_out     = alpha_ff;
   assign was_stretched = stretched_ff;

endmodule

>>> hdl/rgbcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbcs_ctrl
// Sequencer: accepts beats, runs the divider steps and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module rgbcs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_command,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rgbcs_pkg::ctrl_cmd_type  cmd
);

   localparam int unsigned CW = rgbcs_pkg::CNT_W;
   localparam logic [CW-1:0] LAST_STEP = CW'(rgbcs_pkg::DIV_STEPS - 1);

   rgbcs_pkg::ctrl_state_type state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rgbcs_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         rgbcs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == rgbcs_pkg::CMD_MEASURE) begin
                  cmd.measure = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  count_in = '0;
                  state_in = rgbcs_pkg::ST_CALC;
               end
            end
         end
         rgbcs_pkg::ST_CALC: begin
            cmd.step = 1'b1;
            if (count_ff == LAST_STEP) begin
               count_in = '0;
               state_in = rgbcs_pkg::ST_WRITE;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         rgbcs_pkg::ST_WRITE: begin
            if (out_free) begin
               cmd.write = 1'b1;
               state_in  = rgbcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rgbcs_pkg::ST_IDLE;
            count_in = '0;
         end
      endcase
      if (cmd.write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_starts_calc: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == rgbcs_pkg::ST_CALC) && (count_ff == '0))
      else $error("load did not start the divider from step zero");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> rsp_valid_ff)
      else $error("written result not flagged valid");

   a_idle_count_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rgbcs_pkg::ST_IDLE) |-> (count_ff == '0))
      else $error("step counter not clear while idle");

   a_write_when_free: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == rgbcs_pkg::ST_WRITE) && !rsp_valid_ff) |=>
         (state_ff == rgbcs_pkg::ST_IDLE) && rsp_valid_ff)
      else $error("free output register was not written");

endmodule

>>> hdl/rgb_contrast_stretch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_contrast_stretch_top
// Min-max contrast stretch for BGRA pixels, measure pass then stretch pass.
// ----------------------------------------------------------------------------
// The host sends each frame twice. A measure beat (command 0) folds red,
// green and blue into running minima and maxima; a frame_start mark on it
// restarts them first. A stretch beat (command 1) maps each colour channel
// to floor(255*(v-min)/(max-min)), clamped to 0..255, passes alpha through
// and produces one result beat; a flat or empty channel (max not above min)
// gives 0. With enabled cleared the pixel comes back unchanged and
// was_stretched is 0. A stretch beat occupies the block while it is captured,
// while the bit-serial restoring dividers run (one quotient bit per cycle,
// the three channels side by side) and while the output register is written;
// no new beat is accepted before that write. The output register decouples
// the sides: measure beats and the next stretch beat are accepted while a
// result still waits for rsp_ready, and only the final write waits for the
// register to be free. The enabled register is sampled when a stretch beat
// is accepted.
// ----------------------------------------------------------------------------
module rgb_contrast_stretch_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic        req_frame_start,
   input  logic [7:0]  req_blue_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_alpha_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_blue_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_alpha_out,
   output logic        rsp_was_stretched,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   // Command bundle from the sequencer to the datapath.
   rgbcs_pkg::ctrl_cmd_type cmd;

   // The sequencer decides when a beat is taken and which datapath step runs.
   rgbcs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd)
   );

   // The datapath holds the statistics, the dividers and the result payload.
   rgbcs_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .frame_start   (req_frame_start),
      .blue_in       (req_blue_in),
      .green_in      (req_green_in),
      .red_in        (req_red_in),
      .alpha_in      (req_alpha_in),
      .blue_out      (rsp_blue_out),
      .green_out     (rsp_green_out),
      .red_out       (rsp_red_out),
      .alpha_out     (rsp_alpha_out),
      .was_stretched (rsp_was_stretched)
   );

endmodule

>>> verif/rgb_contrast_stretch_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_contrast_stretch_top_tb
// Self-checking bench for the RGB min-max contrast stretch block.
// ----------------------------------------------------------------------------
// Pixels are offered on the request side in bursts with random gaps, and
// results are taken on the response side under a receive pattern that changes
// from phase to phase. A local model of the statistics and the enable register
// works out the pixel that every accepted stretch beat must produce, and each
// response beat is compared with the oldest of those, field by field.
// ----------------------------------------------------------------------------
module rgb_contrast_stretch_top_tb;

   localparam int          CLK_HALF     = 5;
   localparam int          DRAIN_CYCLES = 16;   // well past the time a stretch beat takes
   localparam int          REPORT_LIMIT = 10;
   localparam int unsigned LEVEL_FULL   = rgbcs_pkg::PIX_MAX;

   // Channel positions in the statistics arrays.
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   // Receive patterns for the response side.
   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
      logic       was_stretched;
   } stretched_pixel_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_command = rgbcs_pkg::CMD_MEASURE;
   logic       req_frame_start = 1'b0;
   logic [7:0] req_blue_in = 8'h00;
   logic [7:0] req_green_in = 8'h00;
   logic [7:0] req_red_in = 8'h00;
   logic [7:0] req_alpha_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_blue_out;
   logic [7:0] rsp_green_out;
   logic [7:0] rsp_red_out;
   logic [7:0] rsp_alpha_out;
   logic       rsp_was_stretched;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   // Local copy of the block's state: enable register and running statistics.
   logic       enable_copy = 1'b1;
   logic [7:0] level_min [3] = '{rgbcs_pkg::PIX_MAX, rgbcs_pkg::PIX_MAX,
                                 rgbcs_pkg::PIX_MAX};
   logic [7:0] level_max [3] = '{rgbcs_pkg::PIX_ZERO, rgbcs_pkg::PIX_ZERO,
                                 rgbcs_pkg::PIX_ZERO};

   // Pixels that the block still owes us, oldest first.
   stretched_pixel_type owed_pixels [$];

   int          fault_count = 0;
   int unsigned beats_sent  = 0;
   int unsigned burst_left  = 0;
   logic        gaps_on     = 1'b1;
   rx_mode_type rx_mode     = RX_ALWAYS;
   int unsigned rx_hold     = 0;
   int unsigned rx_tick     = 0;

   always #(CLK_HALF) clock = ~clock;

   rgb_contrast_stretch_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_frame_start   (req_frame_start),
      .req_blue_in       (req_blue_in),
      .req_green_in      (req_green_in),
      .req_red_in        (req_red_in),
      .req_alpha_in      (req_alpha_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_red_out       (rsp_red_out),
      .rsp_alpha_out     (rsp_alpha_out),
      .rsp_was_stretched (rsp_was_stretched),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // floor(255*(v-lo)/(hi-lo)) clamped to a full level. A channel whose
   // maximum is not above its minimum has no usable span and gives zero, as
   // does any value at or below the minimum.
   function automatic logic [7:0] stretch_level(input logic [7:0] v, input logic [7:0] lo,
                                                input logic [7:0] hi);
      int unsigned span;
      int unsigned quot;
      if (hi <= lo) return rgbcs_pkg::PIX_ZERO;
      if (v <= lo) return rgbcs_pkg::PIX_ZERO;
      span = int'(hi) - int'(lo);
      quot = (LEVEL_FULL * (int'(v) - int'(lo))) / span;
      return (quot > LEVEL_FULL) ? rgbcs_pkg::PIX_MAX : quot[7:0];
   endfunction

   // Applies one accepted beat to the local state. A measure beat folds the
   // colours into the statistics, restarting them first on a frame start; a
   // stretch beat ignores the frame start mark and queues its result.
   task automatic track_pixel(input logic cmd, input logic fs, input pixel_type p);
      logic [7:0]          lv [3];
      stretched_pixel_type res;
      lv[CH_BLUE]  = p.blue;
      lv[CH_GREEN] = p.green;
      lv[CH_RED]   = p.red;
      if (cmd == rgbcs_pkg::CMD_MEASURE) begin
         for (int c = 0; c < 3; c++) begin
            if (fs) begin
               level_min[c] = rgbcs_pkg::PIX_MAX;
               level_max[c] = rgbcs_pkg::PIX_ZERO;
            end
            if (lv[c] < level_min[c]) level_min[c] = lv[c];
            if (lv[c] > level_max[c]) level_max[c] = lv[c];
         end
      end else begin
         if (enable_copy) begin
            res.blue  = stretch_level(lv[CH_BLUE], level_min[CH_BLUE], level_max[CH_BLUE]);
            res.green = stretch_level(lv[CH_GREEN], level_min[CH_GREEN], level_max[CH_GREEN]);
            res.red   = stretch_level(lv[CH_RED], level_min[CH_RED], level_max[CH_RED]);
         end else begin
            res.blue  = p.blue;
            res.green = p.green;
            res.red   = p.red;
         end
         res.alpha         = p.alpha;
         res.was_stretched = enable_copy;
         owed_pixels.push_back(res);
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // The receive pattern is driven on the falling edge. A hold request from a
   // test is counted down here, one cycle at a time, with ready kept low.
   always @(negedge clock) begin
      rx_tick = rx_tick + 1;
      if (rx_hold != 0) begin
         rsp_ready = 1'b0;
         rx_hold   = rx_hold - 1;
      end else begin
         case (rx_mode)
            RX_ALWAYS: begin
               rsp_ready = 1'b1;
            end
            RX_RANDOM: begin
               rsp_ready = 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
               rsp_ready = ($urandom_range(0, 3) == 0);
            end
            default: begin
               rsp_ready = ((rx_tick % 7) < 3);
            end
         endcase
      end
   end

   // Every response beat is matched against the oldest owed pixel.
   always @(posedge clock) begin
      stretched_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_pixels.size() == 0) begin
            fault_count = fault_count + 1;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected response beat: b=%0d g=%0d r=%0d a=%0d s=%0d",
                        rsp_blue_out, rsp_green_out, rsp_red_out, rsp_alpha_out,
                        rsp_was_stretched);
         end else begin
            want = owed_pixels.pop_front();
            if (rsp_blue_out !== want.blue || rsp_green_out !== want.green ||
                rsp_red_out !== want.red || rsp_alpha_out !== want.alpha ||
                rsp_was_stretched !== want.was_stretched) begin
               fault_count = fault_count + 1;
               if (fault_count <= REPORT_LIMIT)
                  $display("mismatch b/g/r/a/s: want %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                           want.blue, want.green, want.red, want.alpha, want.was_stretched,
                           rsp_blue_out, rsp_green_out, rsp_red_out, rsp_alpha_out,
                           rsp_was_stretched);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   function automatic pixel_type make_pixel(input logic [7:0] b, input logic [7:0] g,
                                            input logic [7:0] r, input logic [7:0] a);
      pixel_type p;
      p.blue  = b;
      p.green = g;
      p.red   = r;
      p.alpha = a;
      return p;
   endfunction

   // Offers one beat and waits for it to be taken. Valid is left high on
   // return, so a following call extends the burst without a bubble; once
   // the burst is used up a random gap follows with valid low.
   task automatic send_pixel(input logic cmd, input logic fs, input pixel_type p);
      int unsigned gap;
      @(negedge clock);
      req_valid       = 1'b1;
      req_command     = cmd;
      req_frame_start = fs;
      req_blue_in     = p.blue;
      req_green_in    = p.green;
      req_red_in      = p.red;
      req_alpha_in    = p.alpha;
      do @(posedge clock); while (!req_ready);
      track_pixel(cmd, fs, p);
      beats_sent = beats_sent + 1;
      if (gaps_on) begin
         if (burst_left != 0) burst_left = burst_left - 1;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Stops offering beats and waits until every owed pixel has come back,
   // then allows the block time to finish any trailing measure beats.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (owed_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   // Only ever called with the block idle.
   task automatic write_enable(input logic value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      enable_copy = value;
   endtask

   task automatic set_receiver(input rx_mode_type mode, input int unsigned hold);
      @(posedge clock);
      rx_mode = mode;
      rx_hold = hold;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Straight out of reset the statistics are empty, so every channel has no
   // span and stretches to zero. A frame start mark on a stretch beat must
   // not restart anything.
   task automatic test_reset_state();
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b0, make_pixel(8'h80, 8'hff, 8'h01, 8'hff));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b1, make_pixel(8'hff, 8'h00, 8'h7f, 8'h00));
   endtask

   // Full-range frame: 0 and 255 in every channel gives the identity map.
   task automatic test_full_range();
      send_pixel(rgbcs_pkg::CMD_MEASURE, 1'b1, make_pixel(8'h00, 8'h00, 8'h00, 8'h00));
      send_pixel(rgbcs_pkg::CMD_MEASURE, 1'b0, make_pixel(8'hff, 8'hff, 8'hff, 8'hff));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b0, make_pixel(8'h00, 8'hff, 8'h80, 8'h00));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b1, make_pixel(8'hff, 8'h00, 8'h01, 8'hff));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b0, make_pixel(8'h80, 8'h01, 8'hfe, 8'h5a));
   endtask

   // A flat blue channel, and values below the minimum and above the maximum
   // on green and red, which must clamp to zero and to a full level.
   task automatic test_flat_and_clamp();
      send_pixel(rgbcs_pkg::CMD_MEASURE, 1'b1, make_pixel(8'd100, 8'd50, 8'd7, 8'h11));
      send_pixel(rgbcs_pkg::CMD_MEASURE, 1'b0, make_pixel(8'd100, 8'd90, 8'd200, 8'h22));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b0, make_pixel(8'd20, 8'd20, 8'd3, 8'h33));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b0, make_pixel(8'd200, 8'd200, 8'd255, 8'h44));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b0, make_pixel(8'd100, 8'd70, 8'd100, 8'h55));
   endtask

   // With the block disabled stretch beats come back untouched, while measure
   // beats still feed the statistics; that shows once it is enabled again.
   task automatic test_bypass();
      wait_drained();
      write_enable(1'b0);
      send_pixel(rgbcs_pkg::CMD_MEASURE, 1'b1, make_pixel(8'd10, 8'd20, 8'd30, 8'h00));
      send_pixel(rgbcs_pkg::CMD_MEASURE, 1'b0, make_pixel(8'd110, 8'd220, 8'd130, 8'h00));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b0, make_pixel(8'hff, 8'h00, 8'ha5, 8'hff));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b1, make_pixel(8'h00, 8'hff, 8'h5a, 8'h00));
      wait_drained();
      write_enable(1'b1);
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b0, make_pixel(8'd60, 8'd120, 8'd80, 8'hc3));
      send_pixel(rgbcs_pkg::CMD_STRETCH, 1'b0, make_pixel(8'd110, 8'd221, 8'd29, 8'h3c));
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering beats with no gaps, so the output register fills and the
   // request side has to stall. Afterwards the sender waits for every pixel.
   task automatic test_backpressure();
      wait_drained();
      set_receiver(RX_ALWAYS, 300);
      gaps_on = 1'b0;
      send_pixel(rgbcs_pkg::CMD_MEASURE, 1'b1, make_pixel(8'd0, 8'd40, 8'd90, 8'h00));
      send_pixel(rgbcs_pkg::CMD_MEASURE, 1'b0, make_pixel(8'd250, 8'd160, 8'd91, 8'h00));
      for (int i = 0; i < 30; i++) begin
         send_pixel((i % 3 == 2) ? rgbcs_pkg::CMD_MEASURE : rgbcs_pkg::CMD_STRETCH, 1'b0,
                    make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      end
      gaps_on = 1'b1;
      wait_drained();
   endtask

   // One frame: a measure pass with a frame start on the first pixel, then a
   // stretch pass over the same pixels. Each channel draws from a window of
   // its own, sometimes the full range and sometimes a single flat level.
   // A few frames lose their frame start, and some stretch pixels are
   // replaced with random noise that can lie outside the measured window.
   task automatic run_frame();
      int unsigned lo [3];
      int unsigned hi [3];
      int unsigned n;
      int unsigned pick;
      int unsigned x;
      int unsigned y;
      logic        fs;
      pixel_type   frame [$];
      pixel_type   p;
      n = $urandom_range(1, 12);
      for (int c = 0; c < 3; c++) begin
         pick = $urandom_range(0, 9);
         x    = $urandom_range(0, 255);
         y    = $urandom_range(0, 255);
         if (pick < 2) begin
            lo[c] = 0;
            hi[c] = 255;
         end else if (pick == 2) begin
            lo[c] = x;
            hi[c] = x;
         end else begin
            lo[c] = (x < y) ? x : y;
            hi[c] = (x < y) ? y : x;
         end
      end
      for (int i = 0; i < n; i++) begin
         p.blue  = 8'($urandom_range(hi[CH_BLUE], lo[CH_BLUE]));
         p.green = 8'($urandom_range(hi[CH_GREEN], lo[CH_GREEN]));
         p.red   = 8'($urandom_range(hi[CH_RED], lo[CH_RED]));
         p.alpha = 8'($urandom);
         frame.push_back(p);
      end
      fs = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < n; i++)
         send_pixel(rgbcs_pkg::CMD_MEASURE, (i == 0) ? fs : ($urandom_range(0, 15) == 0),
                    frame[i]);
      for (int i = 0; i < n; i++) begin
         p = frame[i];
         if ($urandom_range(0, 4) == 0)
            p = make_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         send_pixel(rgbcs_pkg::CMD_STRETCH, 1'($urandom_range(0, 1)), p);
      end
   endtask

   // Random frames in several phases, each with its own enable setting and
   // receive pattern. The register is only written between phases, once the
   // block has drained.
   task automatic test_random_frames();
      logic        phase_enable [5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      rx_mode_type phase_rx     [5] = '{RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PERIODIC,
                                        RX_RANDOM};
      int unsigned phase_start;
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         write_enable(phase_enable[ph]);
         set_receiver(phase_rx[ph], 0);
         phase_start = beats_sent;
         while (beats_sent - phase_start < 255) run_frame();
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_full_range();
      test_flat_and_clamp();
      test_bypass();
      test_backpressure();
      test_random_frames();
      wait_drained();
      if (fault_count == 0 && owed_pixels.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // A correct run ends far sooner than this; the timeout only stops a run
   // that hangs.
   initial begin
      #(5_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
